>>> rtl/core/zpad_pkg.sv
`default_nettype none

package zpad_pkg;

    localparam int WORD_W         = 32;
    localparam int CFG_DIM_W      = 11;
    localparam int CFG_PAD_W      = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int DEF_NUM_IMAGES = 1;
    localparam int DEF_MAX_DIM    = 1024;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_ROWS  = 3'd0,
        REG_SRC_COLS  = 3'd1,
        REG_SRC_ALIGN = 3'd2,
        REG_CHANNELS  = 3'd3,
        REG_PAD_WIDTH = 3'd4,
        REG_DST_ROWS  = 3'd5,
        REG_DST_COLS  = 3'd6,
        REG_DST_ALIGN = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [CFG_DIM_W-1:0] src_rows;
        logic [CFG_DIM_W-1:0] src_cols;
        logic [CFG_PAD_W-1:0] src_align_pad;
        logic [CFG_DIM_W-1:0] channels;
        logic [CFG_PAD_W-1:0] pad_width;
        logic [CFG_DIM_W-1:0] dst_rows;
        logic [CFG_DIM_W-1:0] dst_cols;
        logic [CFG_PAD_W-1:0] dst_align_pad;
    } cfg_t;

    // Flags of the walk position currently presented
    typedef struct packed {
        logic in_win;         // copy window word
        logic leave_win_row;  // last word of a window row, channel continues
        logic row_end;        // last word of a channel
        logic batch_end;      // last word of the batch
        logic irregular;      // channel wrap that does not step the base by one
    } walk_evt_t;

    typedef struct packed {
        logic [WORD_W-1:0] out_word;
        logic [WORD_W-1:0] dest_index;
        logic              took_source;
        logic [WORD_W-1:0] src_index;
        logic              last;
    } result_t;

    // Source address generator sequencer
    typedef enum logic [1:0] {
        AG_RUN,
        AG_MUL1,
        AG_MUL2,
        AG_SUM
    } ag_state_t;

    // Width of a saturated dimension value (0..max_dim)
    function automatic int dim_w(input int max_dim);
        return $clog2(max_dim + 1);
    endfunction

    // Width of a row or channel counter (0..max_dim-1)
    function automatic int row_w(input int max_dim);
        return $clog2(max_dim);
    endfunction

    // Width of a column counter, alignment columns included
    function automatic int col_w(input int max_dim);
        return $clog2(max_dim + 16);
    endfunction

    function automatic int img_w(input int num_images);
        return (num_images > 1) ? $clog2(num_images) : 1;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/zpad_walker.sv
`default_nettype none

module zpad_walker #(
    parameter int NUM_IMAGES = zpad_pkg::DEF_NUM_IMAGES,
    parameter int MAX_DIM    = zpad_pkg::DEF_MAX_DIM
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  zpad_pkg::cfg_t                          cfg,
    input  logic                                    advance,
    output zpad_pkg::walk_evt_t                     evt,
    output logic [zpad_pkg::WORD_W-1:0]             dest_index,
    output logic [zpad_pkg::img_w(NUM_IMAGES)-1:0]  img_count,
    output logic [zpad_pkg::row_w(MAX_DIM)-1:0]     ch_count,
    output logic [zpad_pkg::row_w(MAX_DIM)-1:0]     row_off,
    output logic [zpad_pkg::col_w(MAX_DIM)-1:0]     col_off,
    output logic [zpad_pkg::dim_w(MAX_DIM)-1:0]     s_rows,
    output logic [zpad_pkg::dim_w(MAX_DIM)-1:0]     n_ch,
    output logic [zpad_pkg::dim_w(MAX_DIM):0]       stride
);
    import zpad_pkg::*;

    localparam int IMG_W = img_w(NUM_IMAGES);
    localparam int ROW_W = row_w(MAX_DIM);
    localparam int COL_W = col_w(MAX_DIM);
    localparam int DIM_W = dim_w(MAX_DIM);
    // Wide enough for a raw register value as well as the column span
    localparam int CW    = ((COL_W > CFG_DIM_W) ? COL_W : CFG_DIM_W) + 1;

    logic [IMG_W-1:0]  img_count_reg, img_count_next;
    logic [ROW_W-1:0]  ch_count_reg, ch_count_next;
    logic [ROW_W-1:0]  row_count_reg, row_count_next;
    logic [COL_W-1:0]  col_count_reg, col_count_next;
    logic [WORD_W-1:0] dest_offset_reg, dest_offset_next;

    logic [CW-1:0] max_x;
    logic [CW-1:0] src_rows_x, src_cols_x, channels_x, dst_rows_x, dst_cols_x;
    logic [CW-1:0] s_rows_x, s_cols_x, n_ch_x, d_rows_x, d_cols_x;
    logic [CW-1:0] row_sum_x, row_len_x, pad_x, r_x, c_x, ch_x;
    logic          row_in, in_win, end_col, end_row, end_ch, end_img;

    // Saturate and floor the configured dimensions
    always_comb
    begin
        max_x      = CW'(MAX_DIM);
        src_rows_x = CW'(cfg.src_rows);
        src_cols_x = CW'(cfg.src_cols);
        channels_x = CW'(cfg.channels);
        dst_rows_x = CW'(cfg.dst_rows);
        dst_cols_x = CW'(cfg.dst_cols);
        s_rows_x   = (src_rows_x > max_x) ? max_x : src_rows_x;
        s_cols_x   = (src_cols_x > max_x) ? max_x : src_cols_x;
        n_ch_x     = (channels_x > max_x) ? max_x : channels_x;
        if (n_ch_x == '0)
        begin
            n_ch_x = CW'(1);
        end
        d_rows_x   = (dst_rows_x > max_x) ? max_x : dst_rows_x;
        if (d_rows_x == '0)
        begin
            d_rows_x = CW'(1);
        end
        d_cols_x   = (dst_cols_x > max_x) ? max_x : dst_cols_x;
        row_sum_x  = d_cols_x + CW'(cfg.dst_align_pad);
        row_len_x  = (row_sum_x == '0) ? CW'(1) : row_sum_x;
    end

    // Window test and end-of-span flags for the current position
    always_comb
    begin
        pad_x   = CW'(cfg.pad_width);
        r_x     = CW'(row_count_reg);
        c_x     = CW'(col_count_reg);
        ch_x    = CW'(ch_count_reg);
        row_in  = (r_x >= pad_x) && (r_x < pad_x + s_rows_x);
        in_win  = row_in && (c_x >= pad_x) && (c_x < pad_x + s_cols_x) && (c_x < d_cols_x);
        end_col = (c_x + CW'(1)) >= row_len_x;
        end_row = end_col && ((r_x + CW'(1)) >= d_rows_x);
        end_ch  = end_row && ((ch_x + CW'(1)) >= n_ch_x);
        end_img = end_ch && (img_count_reg == IMG_W'(NUM_IMAGES - 1));
    end

    always_comb
    begin
        evt.in_win        = in_win;
        evt.leave_win_row = end_col && !end_row && row_in;
        evt.row_end       = end_row;
        evt.batch_end     = end_img;
        evt.irregular     = end_ch && !end_img && (ch_x != n_ch_x - CW'(1));
        dest_index        = dest_offset_reg;
        img_count         = img_count_reg;
        ch_count          = ch_count_reg;
        row_off           = (r_x >= pad_x) ? ROW_W'(r_x - pad_x) : '0;
        col_off           = COL_W'(c_x - pad_x);
        s_rows            = DIM_W'(s_rows_x);
        n_ch              = DIM_W'(n_ch_x);
        stride            = (DIM_W + 1)'(s_cols_x + CW'(cfg.src_align_pad));
    end

    // Counter advance, innermost first
    always_comb
    begin
        img_count_next   = img_count_reg;
        ch_count_next    = ch_count_reg;
        row_count_next   = row_count_reg;
        col_count_next   = col_count_reg;
        dest_offset_next = dest_offset_reg;
        if (advance)
        begin
            if (end_img)
            begin
                img_count_next   = '0;
                ch_count_next    = '0;
                row_count_next   = '0;
                col_count_next   = '0;
                dest_offset_next = '0;
            end
            else
            begin
                dest_offset_next = dest_offset_reg + WORD_W'(1);
                if (!end_col)
                begin
                    col_count_next = COL_W'(c_x + CW'(1));
                end
                else
                begin
                    col_count_next = '0;
                    if (!end_row)
                    begin
                        row_count_next = ROW_W'(r_x + CW'(1));
                    end
                    else
                    begin
                        row_count_next = '0;
                        if (!end_ch)
                        begin
                            ch_count_next = ROW_W'(ch_x + CW'(1));
                        end
                        else
                        begin
                            ch_count_next  = '0;
                            img_count_next = img_count_reg + IMG_W'(1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_count_reg   <= '0;
            ch_count_reg    <= '0;
            row_count_reg   <= '0;
            col_count_reg   <= '0;
            dest_offset_reg <= '0;
        end
        else
        begin
            img_count_reg   <= img_count_next;
            ch_count_reg    <= ch_count_next;
            row_count_reg   <= row_count_next;
            col_count_reg   <= col_count_next;
            dest_offset_reg <= dest_offset_next;
        end
    end

    // Batch end returns the walk to the origin
    a_batch_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        advance && end_img |=> (col_count_reg == '0) && (row_count_reg == '0) &&
            (ch_count_reg == '0) && (img_count_reg == '0) && (dest_offset_reg == '0))
        else $error("walk did not restart after the last item of the batch");

    // Inside a row the column steps by one
    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !end_col && !end_img |=>
            col_count_reg == COL_W'($past(col_count_reg) + COL_W'(1)))
        else $error("column counter did not step by one");

endmodule

`default_nettype wire

>>> rtl/core/zpad_addr_gen.sv
`default_nettype none

module zpad_addr_gen #(
    parameter int NUM_IMAGES = zpad_pkg::DEF_NUM_IMAGES,
    parameter int MAX_DIM    = zpad_pkg::DEF_MAX_DIM
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    recalc_req,
    input  logic                                    advance,
    input  zpad_pkg::walk_evt_t                     evt,
    input  logic [zpad_pkg::img_w(NUM_IMAGES)-1:0]  img_count,
    input  logic [zpad_pkg::row_w(MAX_DIM)-1:0]     ch_count,
    input  logic [zpad_pkg::row_w(MAX_DIM)-1:0]     row_off,
    input  logic [zpad_pkg::col_w(MAX_DIM)-1:0]     col_off,
    input  logic [zpad_pkg::dim_w(MAX_DIM)-1:0]     s_rows,
    input  logic [zpad_pkg::dim_w(MAX_DIM)-1:0]     n_ch,
    input  logic [zpad_pkg::dim_w(MAX_DIM):0]       stride,
    output logic                                    busy,
    output logic [zpad_pkg::WORD_W-1:0]             src_index
);
    import zpad_pkg::*;

    localparam int IMG_W  = img_w(NUM_IMAGES);
    localparam int ROW_W  = row_w(MAX_DIM);
    localparam int DIM_W  = dim_w(MAX_DIM);
    localparam int BASE_W = IMG_W + DIM_W + 1;

    ag_state_t state_reg, state_next;

    logic [WORD_W-1:0]      chan_stride_reg;
    logic [BASE_W-1:0]      base_reg;
    logic [ROW_W-1:0]       row_delta_reg;
    logic [DIM_W:0]         stride_reg;
    logic [WORD_W-1:0]      chan_start_reg;
    logic [WORD_W-1:0]      row_prod_reg;
    logic [WORD_W-1:0]      row_start_reg;

    logic [2*DIM_W:0]         stride_prod;
    logic [IMG_W+DIM_W-1:0]   img_prod;
    logic [BASE_W+WORD_W-1:0] start_prod;
    logic [ROW_W+DIM_W:0]     row_prod;
    logic [WORD_W-1:0]        chan_step;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            AG_RUN:
            begin
                if (recalc_req || (advance && evt.irregular))
                begin
                    state_next = AG_MUL1;
                end
            end
            AG_MUL1:
            begin
                state_next = recalc_req ? AG_MUL1 : AG_MUL2;
            end
            AG_MUL2:
            begin
                state_next = recalc_req ? AG_MUL1 : AG_SUM;
            end
            AG_SUM:
            begin
                state_next = recalc_req ? AG_MUL1 : AG_RUN;
            end
            default:
            begin
                state_next = AG_MUL1;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        busy      = (state_reg != AG_RUN);
        src_index = evt.in_win ? (row_start_reg + WORD_W'(col_off)) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AG_MUL1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Products for the base setup, one multiplier level per step
    always_comb
    begin
        stride_prod = s_rows * stride;
        img_prod    = img_count * n_ch;
        start_prod  = base_reg * chan_stride_reg;
        row_prod    = row_delta_reg * stride_reg;
        chan_step   = chan_start_reg + chan_stride_reg;
    end

    // Channel and row base addresses
    always_ff @(posedge clk)
    begin
        case (state_reg)
            AG_MUL1:
            begin
                chan_stride_reg <= WORD_W'(stride_prod);
                base_reg        <= BASE_W'(img_prod) + BASE_W'(ch_count);
                row_delta_reg   <= row_off;
                stride_reg      <= stride;
            end
            AG_MUL2:
            begin
                chan_start_reg <= start_prod[WORD_W-1:0];
                row_prod_reg   <= WORD_W'(row_prod);
            end
            AG_SUM:
            begin
                row_start_reg <= chan_start_reg + row_prod_reg;
            end
            AG_RUN:
            begin
                if (advance)
                begin
                    if (evt.batch_end)
                    begin
                        chan_start_reg <= '0;
                        row_start_reg  <= '0;
                    end
                    else if (evt.row_end)
                    begin
                        chan_start_reg <= chan_step;
                        row_start_reg  <= chan_step;
                    end
                    else if (evt.leave_win_row)
                    begin
                        row_start_reg <= row_start_reg + WORD_W'(stride_reg);
                    end
                end
            end
            default:
            begin
                row_start_reg <= row_start_reg;
            end
        endcase
    end

    // No item may step the walk while the bases are being rebuilt
    a_run_only: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> state_reg == AG_RUN)
        else $error("item accepted during base address setup");

    // A register write restarts the setup
    a_recalc: assert property (@(posedge clk) disable iff (!rst_n)
        recalc_req |=> state_reg == AG_MUL1)
        else $error("register write did not restart base setup");

endmodule

`default_nettype wire

>>> rtl/core/zpad_out_buf.sv
`default_nettype none

module zpad_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              space,
    input  zpad_pkg::result_t push_data,
    output logic              out_valid,
    input  logic              out_ready,
    output zpad_pkg::result_t out_data
);
    import zpad_pkg::*;

    logic    out_valid_reg, skid_valid_reg;
    result_t out_data_reg, skid_data_reg;
    logic    out_free;

    // Output register plus one skid entry
    always_comb
    begin
        space     = !skid_valid_reg;
        out_free  = !out_valid_reg || out_ready;
        out_valid = out_valid_reg;
        out_data  = out_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        push && out_valid_reg && !out_ready |=> skid_valid_reg)
        else $error("item pushed into a stalled output was dropped");

endmodule

`default_nettype wire

>>> rtl/core/feature_map_zero_padder.sv
// An accepted item's result is registered in the output register, or in the one-entry
// skid if the output stalls. Throughput: one item per cycle while in_ready is high.
// After reset and after every register write, in_ready stays low while the source
// address base is rebuilt with the multipliers; the same setup follows a channel wrap
// that skips channels after a channel count change mid-batch.
// Reset clears the walk counters and loads dimensions 1 and pads 0.
`default_nettype none

module feature_map_zero_padder #(
    parameter int NUM_IMAGES = zpad_pkg::DEF_NUM_IMAGES,
    parameter int MAX_DIM    = zpad_pkg::DEF_MAX_DIM
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [zpad_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [zpad_pkg::CFG_DIM_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [zpad_pkg::WORD_W-1:0]      src_word,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [zpad_pkg::WORD_W-1:0]      out_word,
    output logic [zpad_pkg::WORD_W-1:0]      dest_index,
    output logic                             took_source,
    output logic [zpad_pkg::WORD_W-1:0]      src_index,
    output logic                             last
);
    import zpad_pkg::*;

    localparam int IMG_W = img_w(NUM_IMAGES);
    localparam int ROW_W = row_w(MAX_DIM);
    localparam int COL_W = col_w(MAX_DIM);
    localparam int DIM_W = dim_w(MAX_DIM);

    cfg_t              cfg_reg;
    logic              cfg_write;
    logic              accept;
    logic              busy;
    logic              space;
    walk_evt_t         evt;
    logic [WORD_W-1:0] dest_cur;
    logic [WORD_W-1:0] src_cur;
    logic [IMG_W-1:0]  img_count;
    logic [ROW_W-1:0]  ch_count;
    logic [ROW_W-1:0]  row_off;
    logic [COL_W-1:0]  col_off;
    logic [DIM_W-1:0]  s_rows;
    logic [DIM_W-1:0]  n_ch;
    logic [DIM_W:0]    stride;
    result_t           res;
    result_t           res_out;

    // Handshakes
    always_comb
    begin
        cfg_ready = 1'b1;
        cfg_write = cfg_valid && cfg_ready;
        in_ready  = space && !busy;
        accept    = in_valid && in_ready;
    end

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_rows      <= CFG_DIM_W'(1);
            cfg_reg.src_cols      <= CFG_DIM_W'(1);
            cfg_reg.src_align_pad <= '0;
            cfg_reg.channels      <= CFG_DIM_W'(1);
            cfg_reg.pad_width     <= '0;
            cfg_reg.dst_rows      <= CFG_DIM_W'(1);
            cfg_reg.dst_cols      <= CFG_DIM_W'(1);
            cfg_reg.dst_align_pad <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SRC_ROWS:  cfg_reg.src_rows      <= cfg_data;
                REG_SRC_COLS:  cfg_reg.src_cols      <= cfg_data;
                REG_SRC_ALIGN: cfg_reg.src_align_pad <= cfg_data[CFG_PAD_W-1:0];
                REG_CHANNELS:  cfg_reg.channels      <= cfg_data;
                REG_PAD_WIDTH: cfg_reg.pad_width     <= cfg_data[CFG_PAD_W-1:0];
                REG_DST_ROWS:  cfg_reg.dst_rows      <= cfg_data;
                REG_DST_COLS:  cfg_reg.dst_cols      <= cfg_data;
                REG_DST_ALIGN: cfg_reg.dst_align_pad <= cfg_data[CFG_PAD_W-1:0];
                default:       cfg_reg               <= cfg_reg;
            endcase
        end
    end

    zpad_walker #(
        .NUM_IMAGES (NUM_IMAGES),
        .MAX_DIM    (MAX_DIM)
    ) u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .advance    (accept),
        .evt        (evt),
        .dest_index (dest_cur),
        .img_count  (img_count),
        .ch_count   (ch_count),
        .row_off    (row_off),
        .col_off    (col_off),
        .s_rows     (s_rows),
        .n_ch       (n_ch),
        .stride     (stride)
    );

    zpad_addr_gen #(
        .NUM_IMAGES (NUM_IMAGES),
        .MAX_DIM    (MAX_DIM)
    ) u_addr_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .recalc_req (cfg_write),
        .advance    (accept),
        .evt        (evt),
        .img_count  (img_count),
        .ch_count   (ch_count),
        .row_off    (row_off),
        .col_off    (col_off),
        .s_rows     (s_rows),
        .n_ch       (n_ch),
        .stride     (stride),
        .busy       (busy),
        .src_index  (src_cur)
    );

    // Result for the item at the current walk position
    always_comb
    begin
        res.out_word    = evt.in_win ? src_word : '0;
        res.dest_index  = dest_cur;
        res.took_source = evt.in_win;
        res.src_index   = src_cur;
        res.last        = evt.batch_end;
    end

    zpad_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .space     (space),
        .push_data (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (res_out)
    );

    always_comb
    begin
        out_word    = res_out.out_word;
        dest_index  = res_out.dest_index;
        took_source = res_out.took_source;
        src_index   = res_out.src_index;
        last        = res_out.last;
    end

endmodule

`default_nettype wire

>>> sim/zpad_checker.sv
`default_nettype none

module zpad_checker #(
    parameter int NUM_IMAGES = zpad_pkg::DEF_NUM_IMAGES,
    parameter int MAX_DIM    = zpad_pkg::DEF_MAX_DIM
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [zpad_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [zpad_pkg::CFG_DIM_W-1:0] cfg_data,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [zpad_pkg::WORD_W-1:0]    src_word,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [zpad_pkg::WORD_W-1:0]    out_word,
    input  logic [zpad_pkg::WORD_W-1:0]    dest_index,
    input  logic                           took_source,
    input  logic [zpad_pkg::WORD_W-1:0]    src_index,
    input  logic                           last,
    output int                             fail_count,
    output int                             backlog
);
    timeunit 1ns;
    timeprecision 1ps;

    import zpad_pkg::*;

    // Shadow copy of the configuration registers
    logic [CFG_DIM_W-1:0] src_rows_q  = 11'd1;
    logic [CFG_DIM_W-1:0] src_cols_q  = 11'd1;
    logic [CFG_PAD_W-1:0] src_align_q = 4'd0;
    logic [CFG_DIM_W-1:0] channels_q  = 11'd1;
    logic [CFG_PAD_W-1:0] pad_q       = 4'd0;
    logic [CFG_DIM_W-1:0] dst_rows_q  = 11'd1;
    logic [CFG_DIM_W-1:0] dst_cols_q  = 11'd1;
    logic [CFG_PAD_W-1:0] dst_align_q = 4'd0;

    // Walk position of the next destination word
    int unsigned       img_cnt  = 0;
    int unsigned       ch_cnt   = 0;
    int unsigned       row_cnt  = 0;
    int unsigned       col_cnt  = 0;
    logic [WORD_W-1:0] dest_ptr = '0;

    result_t padded_words_q[$];
    int      mismatches = 0;
    int      waiting    = 0;

    assign fail_count = mismatches;
    assign backlog    = waiting;

    function automatic int unsigned clamp_dim(input logic [CFG_DIM_W-1:0] v);
        return (v > MAX_DIM) ? MAX_DIM : v;
    endfunction

    function automatic int unsigned floor_one(input int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    // Produce the padded word for the current position and advance the walk
    task automatic pad_walk_step(input logic [WORD_W-1:0] word, output result_t res);
        int unsigned s_rows, s_cols, n_ch, d_rows, d_cols, row_len, pw;
        logic        hit, end_col, end_row, end_ch, end_img;
        logic [63:0] addr;
        s_rows  = clamp_dim(src_rows_q);
        s_cols  = clamp_dim(src_cols_q);
        n_ch    = floor_one(clamp_dim(channels_q));
        d_rows  = floor_one(clamp_dim(dst_rows_q));
        d_cols  = clamp_dim(dst_cols_q);
        row_len = floor_one(d_cols + dst_align_q);
        pw      = pad_q;

        // copy window, also cut at the real destination columns
        hit = row_cnt >= pw && row_cnt < pw + s_rows &&
              col_cnt >= pw && col_cnt < pw + s_cols && col_cnt < d_cols;
        addr = '0;
        if (hit)
        begin
            addr = 64'(img_cnt) * n_ch + ch_cnt;
            addr = (addr * s_rows + (row_cnt - pw)) & 64'hFFFF_FFFF;
            addr = (addr * (s_cols + src_align_q) + (col_cnt - pw)) & 64'hFFFF_FFFF;
        end

        end_col = col_cnt + 1 >= row_len;
        end_row = end_col && row_cnt + 1 >= d_rows;
        end_ch  = end_row && ch_cnt + 1 >= n_ch;
        end_img = end_ch && img_cnt + 1 >= NUM_IMAGES;

        res.out_word    = hit ? word : '0;
        res.dest_index  = dest_ptr;
        res.took_source = hit;
        res.src_index   = addr[WORD_W-1:0];
        res.last        = end_img;

        // counters at or past a shrunk limit wrap on their next advance
        if (end_img)
        begin
            img_cnt  = 0;
            ch_cnt   = 0;
            row_cnt  = 0;
            col_cnt  = 0;
            dest_ptr = '0;
        end
        else
        begin
            dest_ptr = dest_ptr + 1'b1;
            if (!end_col)
                col_cnt = col_cnt + 1;
            else
            begin
                col_cnt = 0;
                if (!end_row)
                    row_cnt = row_cnt + 1;
                else
                begin
                    row_cnt = 0;
                    if (!end_ch)
                        ch_cnt = ch_cnt + 1;
                    else
                    begin
                        ch_cnt  = 0;
                        img_cnt = img_cnt + 1;
                    end
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            mismatches++;
        end
    endtask

    // Track handshakes, predict on accepted items, compare accepted results
    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t want;
        if (!rst_n)
        begin
            src_rows_q  = 11'd1;
            src_cols_q  = 11'd1;
            src_align_q = 4'd0;
            channels_q  = 11'd1;
            pad_q       = 4'd0;
            dst_rows_q  = 11'd1;
            dst_cols_q  = 11'd1;
            dst_align_q = 4'd0;
            img_cnt     = 0;
            ch_cnt      = 0;
            row_cnt     = 0;
            col_cnt     = 0;
            dest_ptr    = '0;
            padded_words_q.delete();
            waiting <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (padded_words_q.size() == 0)
                begin
                    $error("result with nothing expected: dest_index %h", dest_index);
                    mismatches++;
                end
                else
                begin
                    want = padded_words_q.pop_front();
                    check_field("out_word", want.out_word, out_word);
                    check_field("dest_index", want.dest_index, dest_index);
                    check_field("took_source", 32'(want.took_source), 32'(took_source));
                    check_field("src_index", want.src_index, src_index);
                    check_field("last", 32'(want.last), 32'(last));
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SRC_ROWS:  src_rows_q  = cfg_data;
                    REG_SRC_COLS:  src_cols_q  = cfg_data;
                    REG_SRC_ALIGN: src_align_q = cfg_data[CFG_PAD_W-1:0];
                    REG_CHANNELS:  channels_q  = cfg_data;
                    REG_PAD_WIDTH: pad_q       = cfg_data[CFG_PAD_W-1:0];
                    REG_DST_ROWS:  dst_rows_q  = cfg_data;
                    REG_DST_COLS:  dst_cols_q  = cfg_data;
                    REG_DST_ALIGN: dst_align_q = cfg_data[CFG_PAD_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                pad_walk_step(src_word, want);
                padded_words_q.push_back(want);
            end

            waiting <= padded_words_q.size();
        end
    end

endmodule

`default_nettype wire

>>> sim/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import zpad_pkg::*;

    localparam int RANDOM_ITEMS   = 1100;
    localparam int WATCHDOG_LIMIT = 5000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    cfg_reg_t             cfg_index = REG_SRC_ROWS;
    logic [CFG_DIM_W-1:0] cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [WORD_W-1:0]    src_word  = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [WORD_W-1:0]    out_word;
    logic [WORD_W-1:0]    dest_index;
    logic                 took_source;
    logic [WORD_W-1:0]    src_index;
    logic                 last;

    int fail_count;
    int backlog;
    int send_gap_pct = 0;
    int recv_gap_pct = 0;
    int quiet_cycles = 0;

    always #10 clk = ~clk;

    feature_map_zero_padder u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .src_word   (src_word),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_word   (out_word),
        .dest_index (dest_index),
        .took_source(took_source),
        .src_index  (src_index),
        .last       (last)
    );

    zpad_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .src_word   (src_word),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_word   (out_word),
        .dest_index (dest_index),
        .took_source(took_source),
        .src_index  (src_index),
        .last       (last),
        .fail_count (fail_count),
        .backlog    (backlog)
    );

    // Receiver back-pressure
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_gap_pct);

    // Cycles without any handshake on the configuration, input or output side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("[feature_map_zero_padder] ERROR");
        $finish;
    end

    task automatic set_idling(input int mode);
        case (mode)
            0:       begin send_gap_pct = 12; recv_gap_pct = 54; end
            1:       begin send_gap_pct = 54; recv_gap_pct = 12; end
            default: begin send_gap_pct = 0;  recv_gap_pct = 0;  end
        endcase
    endtask

    // Offer one source word, with random gaps in front of it
    task automatic send_word(input logic [WORD_W-1:0] word);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        src_word <= word;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DIM_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Stop offering and wait until every padded word has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
    endtask

    // Mostly small shapes, now and then zero or beyond the saturation point
    function automatic logic [CFG_DIM_W-1:0] pick_dim();
        case ($urandom_range(19))
            0:       return '0;
            1:       return CFG_DIM_W'($urandom_range(DEF_MAX_DIM + 1, 2047));
            2:       return CFG_DIM_W'(DEF_MAX_DIM);
            3:       return '1;
            default: return CFG_DIM_W'($urandom_range(1, 5));
        endcase
    endfunction

    // Pad registers keep only the low bits; junk goes in the upper ones
    function automatic logic [CFG_DIM_W-1:0] pick_pad();
        logic [CFG_PAD_W-1:0] pad;
        case ($urandom_range(9))
            0:       pad = '1;
            1:       pad = CFG_PAD_W'($urandom);
            default: pad = CFG_PAD_W'($urandom_range(0, 2));
        endcase
        return {(CFG_DIM_W - CFG_PAD_W)'($urandom), pad};
    endfunction

    initial
    begin : stimulus
        cfg_reg_t          idx;
        logic [WORD_W-1:0] word;
        int                sent;
        int                burst;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        set_idling(0);

        // Reset shape: every word is a whole one-word batch
        send_word('0);
        send_word('1);
        send_word(32'hA5C3_5A3C);
        drain();

        // Saturated source width, window cut at dst_cols, zero channels
        write_reg(REG_SRC_ROWS,  11'd2);
        write_reg(REG_SRC_COLS,  11'h7FF);
        write_reg(REG_SRC_ALIGN, 11'h7FF);
        write_reg(REG_CHANNELS,  11'd0);
        write_reg(REG_PAD_WIDTH, 11'd1);
        write_reg(REG_DST_ROWS,  11'd3);
        write_reg(REG_DST_COLS,  11'd3);
        write_reg(REG_DST_ALIGN, 11'd1);
        cfg_valid <= 1'b0;
        for (int i = 0; i < 12; i++)
            send_word(i[0] ? '1 : 32'h0000_0001 << i);
        drain();

        // Zero destination shape and empty copy window
        write_reg(REG_SRC_ROWS,  11'd0);
        write_reg(REG_PAD_WIDTH, 11'd0);
        write_reg(REG_DST_ROWS,  11'd0);
        write_reg(REG_DST_COLS,  11'd0);
        write_reg(REG_DST_ALIGN, 11'd0);
        cfg_valid <= 1'b0;
        send_word(32'hDEAD_BEEF);
        send_word(32'h1234_5678);
        drain();
        write_reg(REG_SRC_ROWS, 11'd1);
        write_reg(REG_SRC_COLS, 11'd0);
        cfg_valid <= 1'b0;
        send_word(32'hFFFF_0000);
        drain();

        // Two channels: the source address strides over the alignment words
        write_reg(REG_SRC_COLS, 11'd1);
        write_reg(REG_CHANNELS, 11'd2);
        write_reg(REG_DST_COLS, 11'd2);
        cfg_valid <= 1'b0;
        repeat (4) send_word($urandom);

        // Random shapes, rewritten between bursts, often in mid-batch
        for (int mode = 0; mode < 3; mode++)
        begin
            set_idling(mode);
            sent = 0;
            while (sent < RANDOM_ITEMS / 3)
            begin
                drain();
                idx = idx.first();
                do
                begin
                    if ($urandom_range(1) == 1)
                    begin
                        if (idx == REG_SRC_ALIGN || idx == REG_PAD_WIDTH ||
                            idx == REG_DST_ALIGN)
                            write_reg(idx, pick_pad());
                        else
                            write_reg(idx, pick_dim());
                    end
                    idx = idx.next();
                end
                while (idx != idx.first());
                cfg_valid <= 1'b0;

                burst = $urandom_range(8, 60);
                repeat (burst)
                begin
                    word = $urandom;
                    case ($urandom_range(7))
                        0:       word = '0;
                        1:       word = '1;
                        default: ;
                    endcase
                    send_word(word);
                end
                sent += burst;
            end
        end

        drain();
        repeat (8) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0)
            $display("[feature_map_zero_padder] OK");
        else
            $display("[feature_map_zero_padder] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
rtl/core/zpad_pkg.sv
rtl/core/zpad_walker.sv
rtl/core/zpad_addr_gen.sv
rtl/core/zpad_out_buf.sv
rtl/core/feature_map_zero_padder.sv
sim/zpad_checker.sv
sim/tb.sv
